// ===== design/mk_pkg.sv =====
// Shared types, constants and the character decoder of the Morse keyer.
// No dependencies; imported by the top level, the sequencer and the datapath.
`default_nettype none

package mk_pkg;

  localparam int unsigned DurW = 16;
  localparam int unsigned LenW = 3;
  localparam int unsigned PatW = 5;
  localparam int unsigned RegIdxW = 3;

  typedef enum logic [1:0] {
    KIND_SYM   = 2'd0,
    KIND_SPACE = 2'd1,
    KIND_BAD   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    SRC_ELEM_ON = 3'd0,
    SRC_EGAP    = 3'd1,
    SRC_CGAP    = 3'd2,
    SRC_WGAP    = 3'd3,
    SRC_ZERO    = 3'd4
  } src_t;

  typedef enum logic [1:0] {
    COND_ALWAYS = 2'd0,
    COND_INPUT  = 2'd1,
    COND_LASTEL = 2'd2
  } cond_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_ON   = 3'd1,
    ST_GAP  = 3'd2,
    ST_CHAR = 3'd3,
    ST_WORD = 3'd4,
    ST_ERR  = 3'd5
  } step_t;

  typedef enum logic [RegIdxW-1:0] {
    REG_DOT   = 3'd0,
    REG_DASH  = 3'd1,
    REG_EGAP  = 3'd2,
    REG_CGAP  = 3'd3,
    REG_WGAP  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic  emit;
    src_t  src;
    logic  led;
    logic  last;
    logic  err_set;
    logic  shift;
    cond_t cond;
    step_t target;
  } mu_t;

  typedef struct packed {
    logic load;
    logic fire;
    src_t src;
    logic led;
    logic last;
    logic err_set;
    logic shift;
  } ctl_t;

  typedef struct packed {
    kind_t kind;
    logic  cnt_last;
    logic  out_free;
  } status_t;

  typedef struct packed {
    kind_t              kind;
    logic [LenW-1:0]    len;
    logic [PatW-1:0]    pat;
  } char_info_t;

  // Code entries: length in the top three bits, then one bit per element
  // (element 0 in the lowest bit), a set bit meaning a dash.
  localparam logic [7:0] LetterRom [26] = '{
    {3'd2, 5'b00010}, {3'd4, 5'b00001}, {3'd4, 5'b00101}, {3'd3, 5'b00001},
    {3'd1, 5'b00000}, {3'd4, 5'b00100}, {3'd3, 5'b00011}, {3'd4, 5'b00000},
    {3'd2, 5'b00000}, {3'd4, 5'b01110}, {3'd3, 5'b00101}, {3'd4, 5'b00010},
    {3'd2, 5'b00011}, {3'd2, 5'b00001}, {3'd3, 5'b00111}, {3'd4, 5'b00110},
    {3'd4, 5'b01011}, {3'd3, 5'b00010}, {3'd3, 5'b00000}, {3'd1, 5'b00001},
    {3'd3, 5'b00100}, {3'd4, 5'b01000}, {3'd3, 5'b00110}, {3'd4, 5'b01001},
    {3'd4, 5'b01101}, {3'd4, 5'b00011}
  };

  localparam logic [PatW-1:0] DigitRom [10] = '{
    5'b11111, 5'b11110, 5'b11100, 5'b11000, 5'b10000,
    5'b00000, 5'b00001, 5'b00011, 5'b00111, 5'b01111
  };

  function automatic char_info_t mk_decode(input logic [7:0] c);
    char_info_t info;
    logic [7:0] u;
    logic [7:0] off;
    info = '{kind: KIND_BAD, len: '0, pat: '0};
    u = c;
    if (c inside {[8'h61:8'h7A]}) begin
      u = c - 8'h20;
    end
    if (u == 8'h20) begin
      info.kind = KIND_SPACE;
    end else if (u inside {[8'h41:8'h5A]}) begin
      off = u - 8'h41;
      info.kind = KIND_SYM;
      info.len = LetterRom[off[4:0]][7:5];
      info.pat = LetterRom[off[4:0]][4:0];
    end else if (u inside {[8'h30:8'h39]}) begin
      off = u - 8'h30;
      info.kind = KIND_SYM;
      info.len = 3'd5;
      info.pat = DigitRom[off[3:0]];
    end
    return info;
  endfunction

endpackage

`default_nettype wire

// ===== design/morse_keyer_top.sv =====
// Top level of the Morse keyer: joins the microcode sequencer and the datapath.
// Depends on mk_pkg, mk_seq and mk_datapath.
//
//   Channel  Direction  Word contents
//   s_*      in         tdata[7:0] ascii_char
//   m_*      out        tdata[0] led_on, tdata[16:1] duration; tuser error; tlast last
//   cfg_*    in         write of one timing register, index 0..4
//
// A letter or digit of n elements gives 2n+1 words, a space or an unsupported
// byte gives one word; one word leaves per microcode emit step.
// A new character is taken only when the sequencer is back at its idle step.
// Output stalls hold the sequencer on its current emit step.
// Reset restores the default timings and clears the error latch.
`default_nettype none

module morse_keyer_top import mk_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // [7:0] ascii_char
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [23:0]        m_tdata,   // [0] led_on, [16:1] duration, rest zero
  output logic               m_tuser,   // [0] error
  output logic               m_tlast,
  input  logic               cfg_we,
  input  logic [RegIdxW-1:0] cfg_index,
  input  logic [DurW-1:0]    cfg_data
);

  ctl_t            ctl;
  status_t         status;
  logic            led_on;
  logic [DurW-1:0] duration;

  mk_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .status   (status),
    .in_ready (s_tready),
    .ctl      (ctl)
  );

  mk_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_char      (s_tdata),
    .ctl          (ctl),
    .status       (status),
    .out_ready    (m_tready),
    .out_valid    (m_tvalid),
    .out_led_on   (led_on),
    .out_duration (duration),
    .out_error    (m_tuser),
    .out_last     (m_tlast)
  );

  assign m_tdata = {7'd0, duration, led_on};

endmodule

`default_nettype wire

// ===== design/mk_seq.sv =====
// Microcode sequencer of the Morse keyer: step counter, control store, jumps.
// Depends on mk_pkg.
`default_nettype none

module mk_seq import mk_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  status_t status,
  output logic    in_ready,
  output ctl_t    ctl
);

  step_t step;
  step_t step_next;
  mu_t   mu;
  logic  advance;

  function automatic mu_t control_store(input step_t s);
    mu_t w;
    w = '{emit: 1'b0, src: SRC_ZERO, led: 1'b0, last: 1'b0, err_set: 1'b0,
          shift: 1'b0, cond: COND_INPUT, target: ST_IDLE};
    case (s)
      ST_IDLE: ;
      ST_ON: begin
        w.emit = 1'b1; w.src = SRC_ELEM_ON; w.led = 1'b1;
        w.cond = COND_ALWAYS; w.target = ST_GAP;
      end
      ST_GAP: begin
        w.emit = 1'b1; w.src = SRC_EGAP; w.shift = 1'b1;
        w.cond = COND_LASTEL; w.target = ST_ON;
      end
      ST_CHAR: begin
        w.emit = 1'b1; w.src = SRC_CGAP; w.last = 1'b1;
        w.cond = COND_ALWAYS; w.target = ST_IDLE;
      end
      ST_WORD: begin
        w.emit = 1'b1; w.src = SRC_WGAP; w.last = 1'b1;
        w.cond = COND_ALWAYS; w.target = ST_IDLE;
      end
      ST_ERR: begin
        w.emit = 1'b1; w.src = SRC_ZERO; w.last = 1'b1; w.err_set = 1'b1;
        w.cond = COND_ALWAYS; w.target = ST_IDLE;
      end
      default: ;
    endcase
    return w;
  endfunction

  assign mu = control_store(step);
  assign advance = !mu.emit || status.out_free;
  assign in_ready = (step == ST_IDLE);

  always_comb begin
    step_next = step;
    case (mu.cond)
      COND_ALWAYS: begin
        if (advance) step_next = mu.target;
      end
      COND_INPUT: begin
        if (in_valid) begin
          case (status.kind)
            KIND_SYM:   step_next = ST_ON;
            KIND_SPACE: step_next = ST_WORD;
            default:    step_next = ST_ERR;
          endcase
        end
      end
      COND_LASTEL: begin
        if (advance) step_next = status.cnt_last ? ST_CHAR : mu.target;
      end
      default: step_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl.load    = in_ready && in_valid;
    ctl.fire    = mu.emit && status.out_free;
    ctl.src     = mu.src;
    ctl.led     = mu.led;
    ctl.last    = mu.last;
    ctl.err_set = mu.err_set;
    ctl.shift   = mu.shift && mu.emit && status.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/mk_datapath.sv =====
// Datapath of the Morse keyer: timing registers, element shifter, error latch
// and the output register. Depends on mk_pkg.
`default_nettype none

module mk_datapath import mk_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [RegIdxW-1:0] cfg_index,
  input  logic [DurW-1:0]    cfg_data,
  input  logic [7:0]         in_char,
  input  ctl_t               ctl,
  output status_t            status,
  input  logic               out_ready,
  output logic               out_valid,
  output logic               out_led_on,
  output logic [DurW-1:0]    out_duration,
  output logic               out_error,
  output logic               out_last
);

  logic [DurW-1:0] dot_time;
  logic [DurW-1:0] dash_time;
  logic [DurW-1:0] element_gap;
  logic [DurW-1:0] char_gap;
  logic [DurW-1:0] word_gap;
  logic            error_latched;
  logic [LenW-1:0] cnt;
  logic [PatW-1:0] pat;
  logic [DurW-1:0] dur_sel;
  char_info_t      info;

  assign info = mk_decode(in_char);

  assign status.kind     = info.kind;
  assign status.cnt_last = (cnt == LenW'(1));
  assign status.out_free = !out_valid || out_ready;

  always_comb begin
    case (ctl.src)
      SRC_ELEM_ON: dur_sel = pat[0] ? dash_time : dot_time;
      SRC_EGAP:    dur_sel = element_gap;
      SRC_CGAP:    dur_sel = char_gap;
      SRC_WGAP:    dur_sel = word_gap;
      default:     dur_sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_time      <= DurW'(100);
      dash_time     <= DurW'(300);
      element_gap   <= DurW'(100);
      char_gap      <= DurW'(300);
      word_gap      <= DurW'(700);
      error_latched <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DOT:  dot_time    <= cfg_data;
          REG_DASH: dash_time   <= cfg_data;
          REG_EGAP: element_gap <= cfg_data;
          REG_CGAP: char_gap    <= cfg_data;
          REG_WGAP: word_gap    <= cfg_data;
          default: ;
        endcase
      end
      if (ctl.fire && ctl.err_set) begin
        error_latched <= 1'b1;
      end
      if (ctl.fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cnt <= info.len;
      pat <= info.pat;
    end else if (ctl.shift) begin
      cnt <= cnt - LenW'(1);
      pat <= pat >> 1;
    end
    if (ctl.fire) begin
      out_led_on   <= ctl.led;
      out_duration <= dur_sel;
      out_error    <= ctl.err_set || error_latched;
      out_last     <= ctl.last;
    end
  end

endmodule

`default_nettype wire

// ===== design/mk_checker.sv =====
// Port-level checks of the Morse keyer, bound to the top level.
// Depends on morse_keyer_top.
`default_nettype none

module mk_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast,
  input logic        cfg_we
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("Output word changed while stalled.");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("Character taken while the previous one is still being sent.");

  a_lit_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> !m_tlast)
    else $error("A lit segment closed a character.");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tuser |=> !m_tvalid || m_tuser)
    else $error("Error flag dropped after an error was seen.");

  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_we |-> s_tready && !m_tvalid)
    else $error("Timing register written while a character was in flight.");

endmodule

bind morse_keyer_top mk_checker u_mk_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tuser   (m_tuser),
  .m_tlast   (m_tlast),
  .cfg_we    (cfg_we)
);

`default_nettype wire

// ===== tb/keyer_segment_checker.sv =====
// Watches the character, segment and register-write channels of the Morse keyer,
// predicts the segment words for each accepted character and compares them.
// Depends on mk_pkg for the register indexes and port widths.
`default_nettype none

module keyer_segment_checker import mk_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  input  logic               s_tready,
  input  logic [7:0]         s_tdata,
  input  logic               m_tvalid,
  input  logic               m_tready,
  input  logic [23:0]        m_tdata,
  input  logic               m_tuser,
  input  logic               m_tlast,
  input  logic               cfg_we,
  input  logic [RegIdxW-1:0] cfg_index,
  input  logic [DurW-1:0]    cfg_data,
  output int                 fail_count,
  output int                 pending,
  output int                 chars_seen,
  output int                 words_seen
);

  localparam logic [DurW-1:0] DotReset  = 16'd100;
  localparam logic [DurW-1:0] DashReset = 16'd300;
  localparam logic [DurW-1:0] EgapReset = 16'd100;
  localparam logic [DurW-1:0] CgapReset = 16'd300;
  localparam logic [DurW-1:0] WgapReset = 16'd700;

  typedef struct packed {
    logic            led_on;
    logic [DurW-1:0] duration;
    logic            error;
    logic            last;
  } segment_t;

  segment_t        expected_segments[$];
  logic [DurW-1:0] dot_len;
  logic [DurW-1:0] dash_len;
  logic [DurW-1:0] elem_gap;
  logic [DurW-1:0] letter_gap;
  logic [DurW-1:0] space_gap;
  logic            fault_latched;
  segment_t        want;

  function automatic string morse_code(input logic [7:0] u);
    case (u)
      "A": return ".-";    "B": return "-...";  "C": return "-.-.";  "D": return "-..";
      "E": return ".";     "F": return "..-.";  "G": return "--.";   "H": return "....";
      "I": return "..";    "J": return ".---";  "K": return "-.-";   "L": return ".-..";
      "M": return "--";    "N": return "-.";    "O": return "---";   "P": return ".--.";
      "Q": return "--.-";  "R": return ".-.";   "S": return "...";   "T": return "-";
      "U": return "..-";   "V": return "...-";  "W": return ".--";   "X": return "-..-";
      "Y": return "-.--";  "Z": return "--..";
      "0": return "-----"; "1": return ".----"; "2": return "..---"; "3": return "...--";
      "4": return "....-"; "5": return "....."; "6": return "-...."; "7": return "--...";
      "8": return "---.."; "9": return "----.";
      default: return "";
    endcase
  endfunction

  function automatic void expand_char(input logic [7:0] c);
    logic [7:0] u;
    string      code;
    u = (c >= "a" && c <= "z") ? c - 8'h20 : c;
    if (u == " ") begin
      expected_segments.push_back('{1'b0, space_gap, fault_latched, 1'b1});
      return;
    end
    code = morse_code(u);
    if (code.len() == 0) begin
      fault_latched = 1'b1;
      expected_segments.push_back('{1'b0, '0, 1'b1, 1'b1});
      return;
    end
    for (int i = 0; i < code.len(); i++) begin
      expected_segments.push_back('{1'b1, (code[i] == "-") ? dash_len : dot_len,
                                    fault_latched, 1'b0});
      expected_segments.push_back('{1'b0, elem_gap, fault_latched, 1'b0});
    end
    expected_segments.push_back('{1'b0, letter_gap, fault_latched, 1'b1});
  endfunction

  function automatic void compare_field(input string field, input int unsigned exp_v,
                                        input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, actual %0d", field, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      dot_len = DotReset;
      dash_len = DashReset;
      elem_gap = EgapReset;
      letter_gap = CgapReset;
      space_gap = WgapReset;
      fault_latched = 1'b0;
      expected_segments.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DOT:  dot_len = cfg_data;
          REG_DASH: dash_len = cfg_data;
          REG_EGAP: elem_gap = cfg_data;
          REG_CGAP: letter_gap = cfg_data;
          REG_WGAP: space_gap = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        expand_char(s_tdata);
        chars_seen++;
      end
      if (m_tvalid && m_tready) begin
        words_seen++;
        if (expected_segments.size() == 0) begin
          $error("unexpected word: led_on %0d duration %0d error %0d last %0d",
                 m_tdata[0], m_tdata[16:1], m_tuser, m_tlast);
          fail_count++;
        end else begin
          want = expected_segments.pop_front();
          compare_field("led_on", want.led_on, m_tdata[0]);
          compare_field("duration", want.duration, m_tdata[16:1]);
          compare_field("error", want.error, m_tuser);
          compare_field("last", want.last, m_tlast);
        end
      end
    end
    pending = expected_segments.size();
  end

endmodule

`default_nettype wire

// ===== tb/morse_keyer_top_test.sv =====
// Testbench top of the Morse keyer: clock, reset, character and register stimulus,
// random back-pressure and the verdict. Depends on mk_pkg, morse_keyer_top and
// keyer_segment_checker.
`default_nettype none

module morse_keyer_top_test;
  import mk_pkg::*;

  localparam int unsigned StallLimit = 2000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [7:0]         s_tdata = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [23:0]        m_tdata;
  logic               m_tuser;
  logic               m_tlast;
  logic               cfg_we = 1'b0;
  logic [RegIdxW-1:0] cfg_index = '0;
  logic [DurW-1:0]    cfg_data = '0;

  int          fail_count;
  int          pending;
  int          chars_seen;
  int          words_seen;
  int unsigned idle_pct = 0;
  int unsigned ready_hold = 0;
  int unsigned hold_len;
  int unsigned quiet_cycles = 0;
  int          settings_used = 1;

  morse_keyer_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  keyer_segment_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending),
    .chars_seen (chars_seen),
    .words_seen (words_seen)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int unsigned idle_len();
    if ($urandom_range(99) >= idle_pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(30, 80);
    return $urandom_range(1, 4);
  endfunction

  always @(negedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
      m_tready <= 1'b0;
    end else begin
      hold_len = idle_len();
      m_tready <= (hold_len == 0);
      if (hold_len != 0) begin
        ready_hold <= hold_len - 1;
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("morse_keyer_top_test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_char(input logic [7:0] c);
    int unsigned gap;
    gap = idle_len();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= c;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic send_text(input string text);
    for (int i = 0; i < text.len(); i++) begin
      send_char(text[i]);
    end
  endtask

  // Lets every outstanding segment drain and the sequencer return to idle.
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (16) @(negedge clk);
  endtask

  task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [DurW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
  endtask

  task automatic write_timings(input logic [DurW-1:0] dot_v, input logic [DurW-1:0] dash_v,
                               input logic [DurW-1:0] egap_v, input logic [DurW-1:0] cgap_v,
                               input logic [DurW-1:0] wgap_v);
    settle();
    write_reg(REG_DOT, dot_v);
    write_reg(REG_DASH, dash_v);
    write_reg(REG_EGAP, egap_v);
    write_reg(REG_CGAP, cgap_v);
    write_reg(REG_WGAP, wgap_v);
    // Indexes beyond the last register must leave the timings untouched.
    if ($urandom_range(1) == 0) begin
      write_reg(RegIdxW'($urandom_range(REG_WGAP + 1, 2 ** RegIdxW - 1)),
                DurW'($urandom_range(65535)));
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [DurW-1:0] pick_timing(input int unsigned floor_v);
    case ($urandom_range(3))
      0: return DurW'(floor_v);
      1: return '1;
      2: return DurW'($urandom_range(40, floor_v));
      default: return DurW'($urandom_range(65535, floor_v));
    endcase
  endfunction

  function automatic logic [7:0] random_symbol();
    logic [7:0] pick;
    pick = 8'($urandom_range(25));
    case ($urandom_range(9))
      0, 1, 2:    return "A" + pick;
      3, 4, 5:    return "a" + pick;
      6, 7:       return "0" + 8'($urandom_range(9));
      default:    return " ";
    endcase
  endfunction

  task automatic run_random(input int count, input int unsigned pct, input bit any_byte);
    write_timings(pick_timing(1), pick_timing(1), pick_timing(0), pick_timing(0),
                  pick_timing(0));
    idle_pct = pct;
    for (int i = 0; i < count; i++) begin
      if (any_byte && $urandom_range(2) == 0) begin
        send_char(8'($urandom_range(255)));
      end else begin
        send_char(random_symbol());
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    idle_pct = 20;
    send_text("Az09 Qm5");
    write_timings(16'd1, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF);
    send_text("0ET Y");
    write_timings(16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF, 16'd0);
    send_text("H8 ");

    run_random(60, 0, 1'b0);
    run_random(60, 25, 1'b0);
    run_random(60, 50, 1'b0);
    run_random(60, 80, 1'b0);

    // Unsupported bytes set the sticky error flag; later characters keep it raised.
    settle();
    idle_pct = 30;
    send_char(8'h00);
    send_text("A ");
    send_char(8'hFF);
    send_char(8'h60);
    send_text("@[{/:");

    run_random(50, 40, 1'b1);
    run_random(50, 0, 1'b1);

    settle();
    $display("Sent %0d characters under %0d timing settings and checked %0d segment words.",
             chars_seen, settings_used, words_seen);
    if (fail_count == 0) begin
      $display("morse_keyer_top_test passed");
    end else begin
      $display("morse_keyer_top_test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
